@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the hasher.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ hw/rtl/sha1h_pkg.sv @@
// Types and constants of the SHA-1 byte stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1h_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Source of the byte shifted into the block register.
  typedef enum logic [1:0] {
    BSEL_INPUT,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  // Round function groups, twenty rounds each.
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } round_grp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;
    logic       round_en;
    round_grp_t round_grp;
    logic       fold;
    logic       emit_load;
    logic [2:0] emit_idx;
    logic       reinit;
  } dp_cmd_t;

  // Initial chaining values.
  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  // Padding marker byte.
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Counter limits.
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [6:0] ROUND_GRP1  = 7'd20;
  localparam logic [6:0] ROUND_GRP2  = 7'd40;
  localparam logic [6:0] ROUND_GRP3  = 7'd60;
  localparam logic [2:0] WORD_LAST   = 3'd4;

  // Round constant of a group.
  function automatic logic [31:0] round_k(round_grp_t grp);
    logic [31:0] k;
    case (grp)
      GRP_CH:   k = 32'h5A827999;
      GRP_PAR1: k = 32'h6ED9EBA1;
      GRP_MAJ:  k = 32'h8F1BBCDC;
      GRP_PAR2: k = 32'hCA62C1D6;
      default:  k = 32'h5A827999;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/sha1_byte_stream_hasher.sv @@
// SHA-1 byte stream hasher, top level.
// Instantiates sha1h_ctrl and sha1h_dp; uses sha1h_pkg.
//
// Input channel (in_valid / in_stall): each word carries data_byte,
// byte_valid and end_of_message. A word with byte_valid appends the byte;
// a word with end_of_message closes the message after its byte.
// Output channel (out_valid / out_stall): five digest words H0..H4 per
// message, tagged with word_index, last_word and length_error.
// Flow: a byte is taken while the controller is idle. The 64th byte of a
// block starts the compression, the round state and then the fold state,
// with in_stall high. End of message: one padding byte per cycle up to the
// block end, one or two compressions, then one digest word per cycle while
// out_stall is low. Input is stalled while the single shared round unit
// compresses a block. A stalled receiver holds the current digest word and
// the block waits; input stays stalled until the fifth word is loaded.
// After the fifth word the chaining state reinitializes and input resumes
// while that word may still wait in the output register.
// Reset (synchronous, rst high) empties the block, clears length and error
// and drops out_valid.
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        length_error
);

  sha1h_pkg::dp_cmd_t cmd;

  // Controller.
  sha1h_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_index     (word_index),
    .last_word      (last_word),
    .cmd            (cmd)
  );

  // Datapath.
  sha1h_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .digest_word  (digest_word),
    .length_error (length_error)
  );

endmodule

@@ hw/rtl/sha1h_ctrl.sv @@
// Controller of the SHA-1 hasher: input and output handshakes, fill count,
// padding sequence, round counter and digest word sequencing. Uses sha1h_pkg.
module sha1h_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                byte_valid,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          word_index,
  output logic                last_word,
  output sha1h_pkg::dp_cmd_t  cmd
);

  sha1h_pkg::state_t state, state_next;
  logic [5:0] fill, fill_next;
  logic [6:0] rcnt, rcnt_next;
  logic [2:0] widx, widx_next;
  logic       pend, pend_next;
  logic       marked, marked_next;
  logic       extra, extra_next;
  logic       last_blk, last_blk_next;
  logic       out_valid_next;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1h_pkg::ST_IDLE;
      fill      <= '0;
      rcnt      <= '0;
      widx      <= '0;
      pend      <= 1'b0;
      marked    <= 1'b0;
      extra     <= 1'b0;
      last_blk  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rcnt      <= rcnt_next;
      widx      <= widx_next;
      pend      <= pend_next;
      marked    <= marked_next;
      extra     <= extra_next;
      last_blk  <= last_blk_next;
      out_valid <= out_valid_next;
    end
  end

  // Output word tags travel with the digest word.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      word_index <= widx;
      last_word  <= (widx == sha1h_pkg::WORD_LAST);
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    rcnt_next      = rcnt;
    widx_next      = widx;
    pend_next      = pend;
    marked_next    = marked;
    extra_next     = extra;
    last_blk_next  = last_blk;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.byte_sel   = sha1h_pkg::BSEL_INPUT;
    cmd.round_grp  = sha1h_pkg::GRP_CH;
    cmd.len_idx    = fill[2:0];
    cmd.emit_idx   = widx;

    // Round group follows the round counter.
    if (rcnt < sha1h_pkg::ROUND_GRP1) begin
      cmd.round_grp = sha1h_pkg::GRP_CH;
    end else if (rcnt < sha1h_pkg::ROUND_GRP2) begin
      cmd.round_grp = sha1h_pkg::GRP_PAR1;
    end else if (rcnt < sha1h_pkg::ROUND_GRP3) begin
      cmd.round_grp = sha1h_pkg::GRP_MAJ;
    end else begin
      cmd.round_grp = sha1h_pkg::GRP_PAR2;
    end

    case (state)
      sha1h_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          pend_next = end_of_message;
          if (byte_valid) begin
            cmd.shift_en = 1'b1;
            fill_next    = fill + 6'd1;
          end
          if (byte_valid && fill == sha1h_pkg::FILL_LAST) begin
            rcnt_next  = '0;
            state_next = sha1h_pkg::ST_ROUND;
          end else if (end_of_message) begin
            state_next = sha1h_pkg::ST_PAD;
          end
        end
      end

      sha1h_pkg::ST_PAD: begin
        // One padding byte per cycle: marker, zeros, then the bit length.
        cmd.shift_en = 1'b1;
        fill_next    = fill + 6'd1;
        if (!marked) begin
          cmd.byte_sel = sha1h_pkg::BSEL_MARK;
          marked_next  = 1'b1;
          if (fill >= sha1h_pkg::LEN_START) begin
            extra_next = 1'b1;
          end
        end else if (fill >= sha1h_pkg::LEN_START && !extra) begin
          cmd.byte_sel = sha1h_pkg::BSEL_LEN;
          if (fill == sha1h_pkg::FILL_LAST) begin
            last_blk_next = 1'b1;
          end
        end else begin
          cmd.byte_sel = sha1h_pkg::BSEL_ZERO;
        end
        if (fill == sha1h_pkg::FILL_LAST) begin
          rcnt_next  = '0;
          state_next = sha1h_pkg::ST_ROUND;
        end
      end

      sha1h_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        rcnt_next    = rcnt + 7'd1;
        if (rcnt == sha1h_pkg::ROUND_LAST) begin
          state_next = sha1h_pkg::ST_FOLD;
        end
      end

      sha1h_pkg::ST_FOLD: begin
        cmd.fold   = 1'b1;
        extra_next = 1'b0;
        if (last_blk) begin
          widx_next  = '0;
          state_next = sha1h_pkg::ST_EMIT;
        end else if (pend) begin
          state_next = sha1h_pkg::ST_PAD;
        end else begin
          state_next = sha1h_pkg::ST_IDLE;
        end
      end

      sha1h_pkg::ST_EMIT: begin
        // Load the next digest word once the output register is free.
        if (!out_valid || !out_stall) begin
          cmd.emit_load = 1'b1;
          widx_next     = widx + 3'd1;
          if (widx == sha1h_pkg::WORD_LAST) begin
            cmd.reinit    = 1'b1;
            fill_next     = '0;
            pend_next     = 1'b0;
            marked_next   = 1'b0;
            extra_next    = 1'b0;
            last_blk_next = 1'b0;
            state_next    = sha1h_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = sha1h_pkg::ST_IDLE;
      end
    endcase

    // Output valid register.
    if (cmd.emit_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ hw/rtl/sha1h_dp.sv @@
// Datapath of the SHA-1 hasher: block and schedule shift register, round
// registers, chaining words, bit length and digest output. Uses sha1h_pkg.
module sha1h_dp (
  input  logic                clk,
  input  logic                rst,
  input  sha1h_pkg::dp_cmd_t  cmd,
  input  logic [7:0]          data_byte,
  output logic [31:0]         digest_word,
  output logic                length_error
);

  logic [511:0] blk;
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  chain [5];
  logic [63:0]  bit_length;
  logic         ovf;

  logic [7:0]   byte_in;
  logic [2:0]   len_sel;
  logic [31:0]  w_cur, w_new, f, tmp;
  logic [31:0]  sum [5];
  logic [64:0]  len_sum;

  // Byte source, round logic and chaining sums.
  always_comb begin
    len_sel = ~cmd.len_idx;
    case (cmd.byte_sel)
      sha1h_pkg::BSEL_INPUT: byte_in = data_byte;
      sha1h_pkg::BSEL_MARK:  byte_in = sha1h_pkg::PAD_MARK;
      sha1h_pkg::BSEL_LEN:   byte_in = bit_length[{len_sel, 3'b000} +: 8];
      default:               byte_in = '0;
    endcase

    // The oldest word is the schedule word of this round.
    w_cur = blk[511:480];
    w_new = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
    w_new = {w_new[30:0], w_new[31]};

    case (cmd.round_grp)
      sha1h_pkg::GRP_CH:  f = (b & c) | (~b & d);
      sha1h_pkg::GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      default:            f = b ^ c ^ d;
    endcase
    tmp = {a[26:0], a[31:27]} + f + e + w_cur + sha1h_pkg::round_k(cmd.round_grp);

    sum[0] = chain[0] + a;
    sum[1] = chain[1] + b;
    sum[2] = chain[2] + c;
    sum[3] = chain[3] + d;
    sum[4] = chain[4] + e;

    len_sum = {1'b0, bit_length} + 65'd8;
  end

  // Block register: bytes shift in during loading, words roll during rounds.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

  // Working variables, chaining words, length and overflow.
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      chain[0]   <= sha1h_pkg::H_INIT0;
      chain[1]   <= sha1h_pkg::H_INIT1;
      chain[2]   <= sha1h_pkg::H_INIT2;
      chain[3]   <= sha1h_pkg::H_INIT3;
      chain[4]   <= sha1h_pkg::H_INIT4;
      a          <= sha1h_pkg::H_INIT0;
      b          <= sha1h_pkg::H_INIT1;
      c          <= sha1h_pkg::H_INIT2;
      d          <= sha1h_pkg::H_INIT3;
      e          <= sha1h_pkg::H_INIT4;
      bit_length <= '0;
      ovf        <= 1'b0;
    end else begin
      if (cmd.shift_en && cmd.byte_sel == sha1h_pkg::BSEL_INPUT) begin
        bit_length <= len_sum[63:0];
        if (len_sum[64]) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.round_en) begin
        a <= tmp;
        b <= a;
        c <= {b[1:0], b[31:2]};
        d <= c;
        e <= d;
      end else if (cmd.fold) begin
        // New chaining words also seed the next block's rounds.
        chain[0] <= sum[0];
        chain[1] <= sum[1];
        chain[2] <= sum[2];
        chain[3] <= sum[3];
        chain[4] <= sum[4];
        a        <= sum[0];
        b        <= sum[1];
        c        <= sum[2];
        d        <= sum[3];
        e        <= sum[4];
      end
    end
  end

  // Digest output register.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      case (cmd.emit_idx)
        3'd0:    digest_word <= chain[0];
        3'd1:    digest_word <= chain[1];
        3'd2:    digest_word <= chain[2];
        3'd3:    digest_word <= chain[3];
        default: digest_word <= chain[4];
      endcase
      length_error <= ovf;
    end
  end

endmodule

@@ hw/rtl/sha1h_checker.sv @@
// Port-level checker for the SHA-1 hasher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sha1h_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic        length_error
);

  logic       mid_take;
  logic [2:0] idx_inc;

  // A word other than the last one is taken, and the index that must follow it.
  assign mid_take = out_valid && !out_stall && !last_word;
  assign idx_inc  = word_index + 3'd1;

  // A stalled digest word holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(digest_word))

  // The last word is exactly the fifth one.
  `ASSERT_SAME(a_last_tag, clk, rst, out_valid, last_word == (word_index == 3'd4))

  // Words of one digest follow back to back once taken.
  `ASSERT_NEXT(a_word_seq, clk, rst, mid_take, out_valid && word_index == $past(idx_inc))

  // Input waits while a digest is still being delivered.
  `ASSERT_SAME(a_in_blocked, clk, rst, out_valid && !last_word, in_stall)

  // The error flag is the same on every word of one digest.
  `ASSERT_NEXT(a_err_steady, clk, rst, mid_take, $stable(length_error))

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_sha1h_checker (.*);
